// ===== hw/rtl/mahf_pkg.sv =====
// ----------------------------------------------------------------------------
// MPEG audio header finder package
// Transfer types, header codes and the standard rate tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mahf_pkg;

    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int OFFSET_OUT_W     = 24;
    localparam int PROD_W           = 27;
    localparam int QUO_W            = 11;

    localparam logic [1:0] VER_MPEG25   = 2'd0;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_MPEG2    = 2'd2;
    localparam logic [1:0] VER_MPEG1    = 2'd3;

    localparam logic [1:0] LAYER_RESERVED = 2'd0;
    localparam logic [1:0] LAYER_III      = 2'd1;
    localparam logic [1:0] LAYER_II       = 2'd2;
    localparam logic [1:0] LAYER_I        = 2'd3;

    localparam logic [1:0] CHM_JOINT  = 2'd1;
    localparam logic [1:0] SIDX_RSV   = 2'd3;
    localparam logic [3:0] BIDX_FREE  = 4'd0;
    localparam logic [3:0] BIDX_BAD   = 4'd15;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [2:0] SYNC_TOP   = 3'b111;

    typedef enum logic [2:0] {
        HDR_OK          = 3'd0,
        HDR_FREE_RATE   = 3'd1,
        HDR_BAD_RATE    = 3'd2,
        HDR_RSV_RATE    = 3'd3,
        HDR_RSV_VERSION = 3'd4,
        HDR_RSV_LAYER   = 3'd5
    } hdr_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } mahf_in_t;

    typedef struct packed {
        logic [OFFSET_OUT_W-1:0] header_offset;
        logic [1:0]              mpeg_version;
        logic [1:0]              layer_code;
        logic [8:0]              bitrate_kbps;
        logic [15:0]             sample_rate_hz;
        logic [QUO_W-1:0]        frame_bytes;
        logic [2:0]              header_status;
        logic                    padding;
        logic [1:0]              chan_mode;
        logic [1:0]              mode_ext;
        logic [3:0]              misc_flags;
        logic [1:0]              emphasis;
    } mahf_out_t;

    localparam logic [8:0] RATE_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [8:0] RATE_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] RATE_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] RATE_V2_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [8:0] RATE_V2_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
    localparam logic [15:0] BASE_RATE [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

    function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                  input logic [1:0] lay,
                                                  input logic [3:0] bidx);
        logic [8:0] rate;
        rate = 9'd0;
        if (ver != VER_RESERVED && lay != LAYER_RESERVED) begin
            if (ver == VER_MPEG1) begin
                case (lay)
                    LAYER_I:  rate = RATE_V1_L1[bidx];
                    LAYER_II: rate = RATE_V1_L2[bidx];
                    default:  rate = RATE_V1_L3[bidx];
                endcase
            end else if (lay == LAYER_I) begin
                rate = RATE_V2_L1[bidx];
            end else begin
                rate = RATE_V2_L23[bidx];
            end
        end
        return rate;
    endfunction

    function automatic logic [15:0] sample_rate_lookup(input logic [1:0] ver,
                                                       input logic [1:0] sidx);
        logic [15:0] rate;
        case (ver)
            VER_MPEG1: rate = BASE_RATE[sidx];
            VER_MPEG2: rate = BASE_RATE[sidx] >> 1;
            VER_MPEG25: rate = BASE_RATE[sidx] >> 2;
            default:   rate = 16'd0;
        endcase
        return rate;
    endfunction

    // Frame size numerator constant, already divided by the version divisor.
    function automatic logic [17:0] frame_const(input logic [1:0] ver,
                                                input logic [1:0] lay);
        logic [17:0] k;
        k = (lay == LAYER_I) ? 18'd48000 : 18'd144000;
        case (ver)
            VER_MPEG1: frame_const = k;
            VER_MPEG2: frame_const = k >> 1;
            default:   frame_const = k >> 2;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mpeg_audio_header_finder.sv =====
// ----------------------------------------------------------------------------
// MPEG audio header finder
// Scans a byte stream for the first frame sync and decodes that header.
// ----------------------------------------------------------------------------
// The input channel takes one byte per transfer, with stream_start marking the
// first byte of a file. While searching, the block takes one byte every cycle.
// The transfer that completes a four-byte header starts the decode, and the
// input stalls until the decode has finished. A header with a valid status
// runs a bit-serial divider for the frame size: the table lookup and multiply
// come first, then the divider steps, then the output register is loaded.
// Headers with a nonzero status skip the divider and go straight from the
// lookup to the output register.
// After a header the block accepts and drops bytes until the next
// stream_start, also while a result waits in the output register. If the
// receiver stalls with a result pending, the next decode holds in its last
// step until the output register is free.
// Reset clears the search state; the block then waits for the first byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_header_finder
    import mahf_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire mahf_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output mahf_out_t      m_data
);

    localparam int EXT_W = (OFFSET_WIDTH > OFFSET_OUT_W) ? OFFSET_WIDTH : OFFSET_OUT_W;
    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);
    localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

    typedef enum logic [2:0] {
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_OUT,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [23:0]             window_reg;
    logic [1:0]              fill_reg;
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [7:0]              b1_reg;
    logic [7:0]              b2_reg;
    logic [7:0]              b3_reg;
    logic [OFFSET_OUT_W-1:0] offset_reg;
    logic [8:0]              brate_reg;
    logic [15:0]             srate_reg;
    hdr_status_t             status_reg;
    logic [PROD_W-1:0]       num_reg;
    logic [15:0]             rem_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    m_valid_reg;
    mahf_out_t               m_data_reg;

    logic                    in_xfer;
    logic                    sync_hit;
    logic [EXT_W-1:0]        pos_ext;
    logic [1:0]              ver;
    logic [1:0]              lay;
    logic [3:0]              bidx;
    logic [1:0]              sidx;
    logic [8:0]              brate;
    logic [15:0]             srate;
    hdr_status_t             status;
    logic [16:0]             rem_shift;
    logic [16:0]             rem_diff;
    logic                    rem_ge;
    logic                    out_free;
    mahf_out_t               result;

    assign s_ready  = state_reg inside {ST_SCAN, ST_DONE};
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign sync_hit = (fill_reg == 2'd3) && (window_reg[23:16] == SYNC_BYTE)
                   && (window_reg[15:13] == SYNC_TOP);
    assign pos_ext  = EXT_W'(pos_reg);

    assign ver  = b1_reg[4:3];
    assign lay  = b1_reg[2:1];
    assign bidx = b2_reg[7:4];
    assign sidx = b2_reg[3:2];

    always_comb begin
        brate = bitrate_lookup(ver, lay, bidx);
        srate = sample_rate_lookup(ver, sidx);
        if (ver == VER_RESERVED) begin
            status = HDR_RSV_VERSION;
        end else if (lay == LAYER_RESERVED) begin
            status = HDR_RSV_LAYER;
        end else if (sidx == SIDX_RSV) begin
            status = HDR_RSV_RATE;
        end else if (bidx == BIDX_BAD) begin
            status = HDR_BAD_RATE;
        end else if (bidx == BIDX_FREE) begin
            status = HDR_FREE_RATE;
        end else begin
            status = HDR_OK;
        end
    end

    assign rem_shift = {rem_reg, num_reg[PROD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, srate_reg};
    assign rem_ge    = rem_shift >= {1'b0, srate_reg};

    always_comb begin
        result.header_offset  = offset_reg;
        result.mpeg_version   = ver;
        result.layer_code     = lay;
        result.bitrate_kbps   = brate_reg;
        result.sample_rate_hz = srate_reg;
        result.frame_bytes    = (status_reg == HDR_OK) ? quo_reg + QUO_W'(b2_reg[1])
                                                       : '0;
        result.header_status  = status_reg;
        result.padding        = b2_reg[1];
        result.chan_mode      = b3_reg[7:6];
        result.mode_ext       = (b3_reg[7:6] == CHM_JOINT) ? b3_reg[5:4] : 2'd0;
        result.misc_flags     = {b3_reg[2], b3_reg[3], b2_reg[0], b1_reg[0]};
        result.emphasis       = b3_reg[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SCAN;
            window_reg  <= '0;
            fill_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_SCAN, ST_DONE: begin
                    if (in_xfer) begin
                        if (s_data.stream_start) begin
                            window_reg <= {16'd0, s_data.data_byte};
                            fill_reg   <= 2'd1;
                            pos_reg    <= '0;
                            state_reg  <= ST_SCAN;
                        end else if (state_reg == ST_SCAN) begin
                            if (fill_reg != 2'd3) begin
                                window_reg <= {window_reg[15:0], s_data.data_byte};
                                fill_reg   <= fill_reg + 2'd1;
                            end else if (sync_hit) begin
                                b1_reg     <= window_reg[15:8];
                                b2_reg     <= window_reg[7:0];
                                b3_reg     <= s_data.data_byte;
                                offset_reg <= pos_ext[OFFSET_OUT_W-1:0];
                                state_reg  <= ST_MUL;
                            end else begin
                                window_reg <= {window_reg[15:0], s_data.data_byte};
                                if (pos_reg != POS_MAX) begin
                                    pos_reg <= pos_reg + OFFSET_WIDTH'(1);
                                end
                            end
                        end
                    end
                end
                ST_MUL: begin
                    brate_reg  <= brate;
                    srate_reg  <= srate;
                    status_reg <= status;
                    num_reg    <= PROD_W'(frame_const(ver, lay)) * PROD_W'(brate);
                    rem_reg    <= '0;
                    quo_reg    <= '0;
                    cnt_reg    <= '0;
                    state_reg  <= (status == HDR_OK) ? ST_DIV : ST_OUT;
                end
                ST_DIV: begin
                    rem_reg <= rem_ge ? rem_diff[15:0] : rem_shift[15:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
                    num_reg <= {num_reg[PROD_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg  <= result;
                        state_reg   <= ST_DONE;
                    end
                end
                default: begin
                    state_reg <= ST_SCAN;
                end
            endcase
        end
    end

    a_frame_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.header_status == HDR_OK || m_data.frame_bytes == '0))
        else $error("frame size given for a header with nonzero status");

    a_hit_starts_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && state_reg == ST_SCAN && sync_hit && !s_data.stream_start)
        |=> state_reg == ST_MUL)
        else $error("sync found without starting the decode");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> srate_reg != 16'd0)
        else $error("divider running with a zero sample rate");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == CNT_LAST) |=> state_reg == ST_OUT)
        else $error("divider did not finish after its last step");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// MPEG audio header finder testbench
// Sends byte streams, each opened by a stream start, through the input
// channel. An independent model of the sync search and header decode predicts
// the one header that each stream may produce. Every header on the output
// channel is compared field by field with the oldest prediction. A short table
// of hand-built streams comes first. Random streams follow, most of them
// holding a valid sync with random header bits, under several idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mahf_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 40;
    localparam int BYTES_PER_PHASE = 175;

    localparam int unsigned SEND_IDLE [4] = '{0, 82, 0, 16};
    localparam int unsigned RECV_STALL [4] = '{0, 0, 82, 16};

    localparam int unsigned V1_L1_KBPS [16] = '{0, 32, 64, 96, 128, 160, 192, 224,
                                                256, 288, 320, 352, 384, 416, 448, 0};
    localparam int unsigned V1_L2_KBPS [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
                                                128, 160, 192, 224, 256, 320, 384, 0};
    localparam int unsigned V1_L3_KBPS [16] = '{0, 32, 40, 48, 56, 64, 80, 96,
                                                112, 128, 160, 192, 224, 256, 320, 0};
    localparam int unsigned V2_L1_KBPS [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
                                                128, 144, 160, 176, 192, 224, 256, 0};
    localparam int unsigned V2_L23_KBPS [16] = '{0, 8, 16, 24, 32, 40, 48, 56,
                                                 64, 80, 96, 112, 128, 144, 160, 0};

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        stream_start;
        logic        typed;
        hdr_status_t status;
        logic [23:0] offset;
        logic [10:0] frame;
    } stim_row_t;

    // Columns: byte, stream start, fixed result given, status, offset, frame size.
    localparam stim_row_t DIRECTED [25] = '{
        '{8'hFF, 1'b1, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hFD, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hEB, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'h7F, 1'b0, 1'b1, HDR_OK,          24'd0, 11'd1729},
        '{8'hFF, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hFF, 1'b1, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hE2, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'h00, 1'b1, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hFF, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hE8, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'h00, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'h00, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'h00, 1'b0, 1'b1, HDR_RSV_VERSION, 24'd1, 11'd0},
        '{8'hFF, 1'b1, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hF0, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hF4, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'h00, 1'b0, 1'b1, HDR_RSV_LAYER,   24'd0, 11'd0},
        '{8'hFF, 1'b1, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hE7, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'h1E, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hF0, 1'b0, 1'b1, HDR_RSV_RATE,    24'd0, 11'd0},
        '{8'hFF, 1'b1, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hFB, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'hF0, 1'b0, 1'b0, HDR_OK,          24'd0, 11'd0},
        '{8'h0C, 1'b0, 1'b1, HDR_BAD_RATE,    24'd0, 11'd0}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    mahf_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    mahf_out_t m_data;

    stim_row_t   cur_row = '0;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_issued = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned streams_sent = 0;
    int unsigned status_count [8];

    logic [23:0] scan_window = '0;
    logic [1:0]  scan_fill = '0;
    logic [23:0] scan_pos = '0;
    logic        sync_locked = 1'b0;

    mahf_out_t   expected_hdr_q [$];
    mahf_out_t   mon_hdr;
    logic [7:0]  stream_buf [$];

    mpeg_audio_header_finder uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic mahf_out_t decode_header(input logic [23:0] pos,
                                                input logic [7:0] b1,
                                                input logic [7:0] b2,
                                                input logic [7:0] b3);
        mahf_out_t   h;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [1:0]  sidx;
        logic [3:0]  bidx;
        hdr_status_t status;
        int unsigned div;
        int unsigned kbps;
        int unsigned hz;
        int unsigned k;
        int unsigned frame;
        h = '0;
        ver = b1[4:3];
        lay = b1[2:1];
        bidx = b2[7:4];
        sidx = b2[3:2];
        div = (ver == VER_MPEG1) ? 1 : (ver == VER_MPEG2) ? 2 : 4;
        kbps = 0;
        hz = 0;
        frame = 0;
        if (ver != VER_RESERVED && lay != LAYER_RESERVED) begin
            if (ver == VER_MPEG1) begin
                kbps = (lay == LAYER_I) ? V1_L1_KBPS[bidx] :
                       (lay == LAYER_II) ? V1_L2_KBPS[bidx] : V1_L3_KBPS[bidx];
            end else begin
                kbps = (lay == LAYER_I) ? V2_L1_KBPS[bidx] : V2_L23_KBPS[bidx];
            end
        end
        if (ver != VER_RESERVED) begin
            case (sidx)
                2'd0: hz = 44100;
                2'd1: hz = 48000;
                2'd2: hz = 32000;
                default: hz = 0;
            endcase
            hz = hz / div;
        end
        if (ver == VER_RESERVED) status = HDR_RSV_VERSION;
        else if (lay == LAYER_RESERVED) status = HDR_RSV_LAYER;
        else if (sidx == SIDX_RSV) status = HDR_RSV_RATE;
        else if (bidx == BIDX_BAD) status = HDR_BAD_RATE;
        else if (bidx == BIDX_FREE) status = HDR_FREE_RATE;
        else status = HDR_OK;
        if (status == HDR_OK) begin
            k = (lay == LAYER_I) ? 48000 : 144000;
            frame = (k / div * kbps) / hz + 32'(b2[1]);
        end
        h.header_offset  = pos;
        h.mpeg_version   = ver;
        h.layer_code     = lay;
        h.bitrate_kbps   = 9'(kbps);
        h.sample_rate_hz = 16'(hz);
        h.frame_bytes    = 11'(frame);
        h.header_status  = status;
        h.padding        = b2[1];
        h.chan_mode      = b3[7:6];
        h.mode_ext       = (b3[7:6] == CHM_JOINT) ? b3[5:4] : 2'b00;
        h.misc_flags     = {b3[2], b3[3], b2[0], b1[0]};
        h.emphasis       = b3[1:0];
        return h;
    endfunction

    // Advances the search by one byte; returns 1 when the byte completes a header.
    function automatic bit scan_byte(input mahf_in_t item, output mahf_out_t hdr);
        hdr = '0;
        if (item.stream_start) begin
            scan_window = '0;
            scan_fill = '0;
            scan_pos = '0;
            sync_locked = 1'b0;
        end
        if (sync_locked) return 1'b0;
        if (scan_fill != 2'd3) begin
            scan_window = {scan_window[15:0], item.data_byte};
            scan_fill = scan_fill + 2'd1;
            return 1'b0;
        end
        if (scan_window[23:16] == SYNC_BYTE && scan_window[15:13] == SYNC_TOP) begin
            sync_locked = 1'b1;
            hdr = decode_header(scan_pos, scan_window[15:8], scan_window[7:0],
                                item.data_byte);
            return 1'b1;
        end
        scan_window = {scan_window[15:0], item.data_byte};
        if (scan_pos != '1) scan_pos = scan_pos + 24'd1;
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            bytes_sent++;
            if (scan_byte(s_data, mon_hdr)) begin
                if (cur_row.typed) begin
                    mon_hdr.header_status = cur_row.status;
                    mon_hdr.header_offset = cur_row.offset;
                    mon_hdr.frame_bytes = cur_row.frame;
                end
                expected_hdr_q.push_back(mon_hdr);
            end
        end
        if (m_valid && m_ready) begin
            if (expected_hdr_q.size() == 0) begin
                $error("header transfer with no header expected");
                error_count++;
            end else begin
                mon_hdr = expected_hdr_q.pop_front();
                status_count[mon_hdr.header_status]++;
                check_field("header_offset", 32'(mon_hdr.header_offset),
                            32'(m_data.header_offset));
                check_field("mpeg_version", 32'(mon_hdr.mpeg_version),
                            32'(m_data.mpeg_version));
                check_field("layer_code", 32'(mon_hdr.layer_code), 32'(m_data.layer_code));
                check_field("bitrate_kbps", 32'(mon_hdr.bitrate_kbps),
                            32'(m_data.bitrate_kbps));
                check_field("sample_rate_hz", 32'(mon_hdr.sample_rate_hz),
                            32'(m_data.sample_rate_hz));
                check_field("frame_bytes", 32'(mon_hdr.frame_bytes), 32'(m_data.frame_bytes));
                check_field("header_status", 32'(mon_hdr.header_status),
                            32'(m_data.header_status));
                check_field("padding", 32'(mon_hdr.padding), 32'(m_data.padding));
                check_field("chan_mode", 32'(mon_hdr.chan_mode),
                            32'(m_data.chan_mode));
                check_field("mode_ext", 32'(mon_hdr.mode_ext),
                            32'(m_data.mode_ext));
                check_field("misc_flags", 32'(mon_hdr.misc_flags), 32'(m_data.misc_flags));
                check_field("emphasis", 32'(mon_hdr.emphasis), 32'(m_data.emphasis));
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_taken != hold_issued) begin
            hold_taken <= hold_issued;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input stim_row_t row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{data_byte: row.data_byte, stream_start: row.stream_start};
        cur_row <= row;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_headers();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_hdr_q.size() != 0);
        @(posedge aclk);
    endtask

    // Mostly a sync with random header bits after some junk, then a few bytes
    // the block drops. Otherwise a sync byte with a bad follower, or a stream
    // too short to hold a header.
    task automatic build_stream(input bit want_header, output int unsigned counted);
        int unsigned kind;
        int unsigned junk;
        stream_buf.delete();
        kind = want_header ? $urandom_range(0, 7) : $urandom_range(0, 9);
        junk = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
        if (kind < 8) begin
            repeat (junk) stream_buf.push_back(8'($urandom_range(0, 255)));
            stream_buf.push_back(SYNC_BYTE);
            if (kind == 0) stream_buf.push_back(SYNC_BYTE);
            else stream_buf.push_back({SYNC_TOP, 5'($urandom_range(0, 31))});
            repeat (2) stream_buf.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) stream_buf.push_back(8'($urandom_range(0, 255)));
            counted = stream_buf.size();
        end else if (kind == 8) begin
            repeat ($urandom_range(0, 3)) stream_buf.push_back(8'($urandom_range(0, 255)));
            stream_buf.push_back(SYNC_BYTE);
            stream_buf.push_back(8'($urandom_range(0, 8'hDF)));
            repeat ($urandom_range(0, 6)) stream_buf.push_back(8'($urandom_range(0, 255)));
            counted = stream_buf.size();
        end else begin
            repeat ($urandom_range(1, 3)) stream_buf.push_back(8'($urandom_range(0, 255)));
            counted = stream_buf.size();
        end
    endtask

    task automatic send_stream(input bit want_header, output int unsigned counted);
        stim_row_t row;
        row = '0;
        build_stream(want_header, counted);
        foreach (stream_buf[i]) begin
            row.data_byte = stream_buf[i];
            row.stream_start = (i == 0);
            send_item(row);
        end
        streams_sent++;
    endtask

    initial begin
        int unsigned phase_bytes;
        int unsigned n;
        foreach (status_count[i]) status_count[i] = 0;
        send_idle_pct = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) send_item(DIRECTED[i]);
        drain_headers();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            recv_stall_pct <= RECV_STALL[ph];
            phase_bytes = 0;
            if (ph == 0) begin
                // The receiver stops for a long stretch while headers keep
                // arriving, so the output fills and the input stalls.
                hold_issued <= hold_issued + 1;
                repeat (3) begin
                    send_stream(1'b1, n);
                    phase_bytes += n;
                end
            end
            while (phase_bytes < BYTES_PER_PHASE) begin
                send_stream(1'b0, n);
                phase_bytes += n;
            end
            drain_headers();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_hdr_q.size() != 0) begin
            $error("%0d expected headers never arrived", expected_hdr_q.size());
            error_count++;
        end
        $display("Streamed %0d bytes in %0d streams under four idling patterns.",
                 bytes_sent, streams_sent);
        $display("Headers ok/free/bad/rsv-rate/rsv-ver/rsv-layer: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_count[HDR_OK], status_count[HDR_FREE_RATE],
                 status_count[HDR_BAD_RATE], status_count[HDR_RSV_RATE],
                 status_count[HDR_RSV_VERSION], status_count[HDR_RSV_LAYER]);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== mpeg_audio_header_finder.f =====
hw/rtl/mahf_pkg.sv
hw/rtl/mpeg_audio_header_finder.sv
tb/tb.sv
